// ===== rtl/ssort_pkg.sv =====
// ssort_pkg: shared types and constants for the selection sort engine.
// Holds the controller/datapath command and status structs.
// No dependencies.
package ssort_pkg;

    localparam int VALUE_W = 32;

    typedef logic signed [VALUE_W-1:0] t_value;

    // Commands from controller to datapath, at most one group active per cycle
    typedef struct packed {
        logic take;        // input item accepted: store it or note the drop
        logic pass_init;   // start sorting at position 0
        logic rd_pos;      // read element at pos, scan <= pos + 1
        logic first_ld;    // latch pos element as running minimum, read scan
        logic scan_step;   // compare element at scan, read next
        logic swap_a;      // write minimum into pos
        logic swap_b;      // write old pos element into best, pos++
        logic emit_first;  // k <= 0, read element 0
        logic out_load;    // load output register from read data
        logic out_next;    // k++, read next element
        logic list_clear;  // list done: count and overflow flag back to 0
    } t_ssort_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic pass_done;   // no unsorted pair left
        logic scan_last;   // current scan index is the last stored element
        logic out_last;    // output register holds the final element
    } t_ssort_status;

endpackage

// ===== rtl/ssort_if.sv =====
// ssort_if: valid/ready channel interfaces for list input and sorted output.
// Depends on ssort_pkg.

interface ssort_in_if import ssort_pkg::*; ();
    logic   valid;
    logic   ready;
    t_value value;
    logic   is_final;

    modport source (output valid, output value, output is_final, input ready);
    modport sink   (input valid, input value, input is_final, output ready);
endinterface

interface ssort_out_if import ssort_pkg::*; ();
    logic   valid;
    logic   ready;
    t_value sorted_value;
    logic   end_of_list;
    logic   overflowed;

    modport source (output valid, output sorted_value, output end_of_list,
                    output overflowed, input ready);
    modport sink   (input valid, input sorted_value, input end_of_list,
                    input overflowed, output ready);
endinterface

// ===== rtl/ssort_dp.sv =====
// ssort_dp: element memory, index counters, running minimum and output register.
// Depends on ssort_pkg; driven by ssort_ctrl commands.
module ssort_dp import ssort_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_ssort_cmd    i_cmd,
    input  t_value        i_value,
    output t_ssort_status o_status,
    output t_value        o_sorted_value,
    output logic          o_end_of_list,
    output logic          o_overflowed
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [VALUE_W-1:0] r_mem [CAPACITY];
    t_value             r_rd_data;

    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic [IW-1:0] r_pos, r_scan, r_best, r_k;
    t_value        r_best_val, r_pos_val;
    t_value        r_out_val;
    logic          r_out_end, r_out_ovf;

    logic               full;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    t_value             wr_data;
    logic               rd_en;
    logic [IW-1:0]      rd_addr;
    logic               scan_last;
    logic               is_less;

    assign full      = (r_count == CW'(CAPACITY));
    assign scan_last = ((CW'(r_scan) + CW'(1)) >= r_count);
    assign is_less   = (r_rd_data < r_best_val);

    // single write port
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_count[IW-1:0];
        wr_data = i_value;
        if (i_cmd.take && !full) begin
            wr_en = 1'b1;
        end else if (i_cmd.swap_a) begin
            wr_en   = 1'b1;
            wr_addr = r_pos;
            wr_data = r_best_val;
        end else if (i_cmd.swap_b) begin
            wr_en   = 1'b1;
            wr_addr = r_best;
            wr_data = r_pos_val;
        end
    end

    // single read port
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_pos;
        if (i_cmd.rd_pos) begin
            rd_en = 1'b1;
        end else if (i_cmd.first_ld) begin
            rd_en   = 1'b1;
            rd_addr = r_scan;
        end else if (i_cmd.scan_step && !scan_last) begin
            rd_en   = 1'b1;
            rd_addr = r_scan + IW'(1);
        end else if (i_cmd.emit_first) begin
            rd_en   = 1'b1;
            rd_addr = '0;
        end else if (i_cmd.out_next) begin
            rd_en   = 1'b1;
            rd_addr = r_k + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // list bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.list_clear) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.take) begin
            if (full) begin
                r_ovf <= 1'b1;
            end else begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    // sort indices and running minimum
    always_ff @(posedge i_clk) begin
        if (i_cmd.pass_init) begin
            r_pos <= '0;
        end
        if (i_cmd.rd_pos) begin
            r_scan <= r_pos + IW'(1);
        end
        if (i_cmd.first_ld) begin
            r_best_val <= r_rd_data;
            r_pos_val  <= r_rd_data;
            r_best     <= r_pos;
        end
        if (i_cmd.scan_step) begin
            if (is_less) begin
                r_best_val <= r_rd_data;
                r_best     <= r_scan;
            end
            if (!scan_last) begin
                r_scan <= r_scan + IW'(1);
            end
        end
        if (i_cmd.swap_b) begin
            r_pos <= r_pos + IW'(1);
        end
        if (i_cmd.emit_first) begin
            r_k <= '0;
        end
        if (i_cmd.out_next) begin
            r_k <= r_k + IW'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_val <= r_rd_data;
            r_out_end <= ((CW'(r_k) + CW'(1)) == r_count);
            r_out_ovf <= r_ovf;
        end
    end

    assign o_status.pass_done = ((CW'(r_pos) + CW'(1)) >= r_count);
    assign o_status.scan_last = scan_last;
    assign o_status.out_last  = r_out_end;

    assign o_sorted_value = r_out_val;
    assign o_end_of_list  = r_out_end;
    assign o_overflowed   = r_out_ovf;

endmodule

// ===== rtl/ssort_ctrl.sv =====
// ssort_ctrl: sequencer for collect, selection passes and emit.
// Depends on ssort_pkg; commands ssort_dp.
module ssort_ctrl import ssort_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_is_final,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  t_ssort_status i_status,
    output t_ssort_cmd    o_cmd
);

    typedef enum logic [7:0] {
        S_COLLECT = 8'b0000_0001,
        S_PASS    = 8'b0000_0010,
        S_FIRST   = 8'b0000_0100,
        S_SCAN    = 8'b0000_1000,
        S_SWAP_A  = 8'b0001_0000,
        S_SWAP_B  = 8'b0010_0000,
        S_LOAD    = 8'b0100_0000,
        S_HOLD    = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_COLLECT: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_in_is_final) begin
                        o_cmd.pass_init = 1'b1;
                        n_state         = S_PASS;
                    end
                end
            end
            S_PASS: begin
                if (i_status.pass_done) begin
                    o_cmd.emit_first = 1'b1;
                    n_state          = S_LOAD;
                end else begin
                    o_cmd.rd_pos = 1'b1;
                    n_state      = S_FIRST;
                end
            end
            S_FIRST: begin
                o_cmd.first_ld = 1'b1;
                n_state        = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_SWAP_A;
                end
            end
            S_SWAP_A: begin
                o_cmd.swap_a = 1'b1;
                n_state      = S_SWAP_B;
            end
            S_SWAP_B: begin
                o_cmd.swap_b = 1'b1;
                n_state      = S_PASS;
            end
            S_LOAD: begin
                o_cmd.out_load = 1'b1;
                n_state        = S_HOLD;
            end
            S_HOLD: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_status.out_last) begin
                        o_cmd.list_clear = 1'b1;
                        n_state          = S_COLLECT;
                    end else begin
                        o_cmd.out_next = 1'b1;
                        n_state        = S_LOAD;
                    end
                end
            end
            default: begin
                n_state = S_COLLECT;
            end
        endcase
    end

endmodule

// ===== rtl/selection_sort_engine.sv =====
// selection_sort_engine: top level of the list sorter, controller plus datapath.
// Depends on ssort_pkg, ssort_if, ssort_ctrl and ssort_dp.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-----------------------------------------
//  i_in    | in  | valid/ready, both high | value[31:0] signed, is_final
//  o_out   | out | valid/ready, both high | sorted_value[31:0] signed, end_of_list,
//          |     |                        | overflowed
//
// Collecting takes one item per cycle until the final item. Then the stored
// elements are sorted in selection passes: each pass reads the element at pos,
// latches it as running minimum, compares each later element in turn and writes
// the two swap entries, all paced by the single-port element memory. Emitting
// reads each result from memory into the output register, held during stalls.
// Reset (synchronous, active low) empties the list; the element memory itself
// is not cleared, since only entries written for the current list are read.
// No input item is taken while a list is being sorted or emitted.
module selection_sort_engine import ssort_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ssort_in_if.sink     i_in,
    ssort_out_if.source  o_out
);

    t_ssort_cmd    cmd;
    t_ssort_status status;

    // sequencer: collect items, run one selection pass after another, emit
    ssort_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in.valid),
        .i_in_is_final (i_in.is_final),
        .o_in_ready    (i_in.ready),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .i_status      (status),
        .o_cmd         (cmd)
    );

    // element memory, running minimum and the output register
    ssort_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_value        (i_in.value),
        .o_status       (status),
        .o_sorted_value (o_out.sorted_value),
        .o_end_of_list  (o_out.end_of_list),
        .o_overflowed   (o_out.overflowed)
    );

endmodule

// ===== rtl/ssort_checker.sv =====
// ssort_checker: port-level assertions for selection_sort_engine, with bind.
// Depends on ssort_pkg.
module ssort_checker import ssort_pkg::*; (
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_in_valid,
    input logic   i_in_ready,
    input logic   i_in_is_final,
    input logic   i_out_valid,
    input logic   i_out_ready,
    input t_value i_sorted_value,
    input logic   i_end_of_list
);

    // input is never taken while results are pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready while a result is offered");

    // a final item that is taken closes the input
    a_final_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_is_final) |=> !i_in_ready)
        else $error("input still open after final item");

    // the last result reopens the input
    a_end_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_end_of_list) |=> i_in_ready)
        else $error("input not reopened after end of list");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_sorted_value)))
        else $error("stalled result changed");

endmodule

bind selection_sort_engine ssort_checker u_ssort_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_is_final  (i_in.is_final),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_sorted_value (o_out.sorted_value),
    .i_end_of_list  (o_out.end_of_list)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking bench for selection_sort_engine, random lists under stalls.
// Depends on ssort_pkg, ssort_if and the engine RTL.

module tb_top;
    import ssort_pkg::*;

    localparam int     DEPTH   = 16;
    localparam t_value VAL_MIN = 32'sh8000_0000;
    localparam t_value VAL_MAX = 32'sh7FFF_FFFF;

    // value mixes for random lists
    typedef enum int {MIX_WIDE, MIX_NARROW, MIX_EXTREME, MIX_ANY} t_value_mix;

    typedef struct {
        t_value value;
        logic   eol;
        logic   ovf;
    } t_sorted_entry;

    // Keeps its own copy of the list buffer; a closing item sorts it and queues
    // the results the engine owes.
    class sorted_list_tracker;
        t_value          held[DEPTH];
        int unsigned     held_count;
        bit              dropped_any;
        t_sorted_entry   due[$];
        int unsigned     errors;
        int unsigned     lists_closed;
        int unsigned     overflow_lists;
        int unsigned     results_checked;

        function new();
            held_count      = 0;
            dropped_any     = 1'b0;
            errors          = 0;
            lists_closed    = 0;
            overflow_lists  = 0;
            results_checked = 0;
        endfunction

        function void take_element(t_value v, logic fin);
            t_value        work[DEPTH];
            t_value        tmp;
            t_sorted_entry e;
            int            best;
            if (held_count < DEPTH) begin
                held[held_count] = v;
                held_count++;
            end else begin
                dropped_any = 1'b1;
            end
            if (!fin)
                return;
            work = held;
            // selection sort, earliest minimum wins on a tie
            for (int p = 0; p + 1 < int'(held_count); p++) begin
                best = p;
                for (int s = p + 1; s < int'(held_count); s++)
                    if (work[s] < work[best])
                        best = s;
                tmp        = work[p];
                work[p]    = work[best];
                work[best] = tmp;
            end
            for (int k = 0; k < int'(held_count); k++) begin
                e.value = work[k];
                e.eol   = (k + 1 == int'(held_count));
                e.ovf   = dropped_any;
                due.push_back(e);
            end
            lists_closed++;
            if (dropped_any)
                overflow_lists++;
            held_count  = 0;
            dropped_any = 1'b0;
        endfunction

        function void check_output(t_value v, logic eol, logic ovf);
            t_sorted_entry e;
            if (due.size() == 0) begin
                errors++;
                $display("%0t: result %0d with none expected", $time, v);
                return;
            end
            e = due.pop_front();
            results_checked++;
            if (v !== e.value) begin
                errors++;
                $display("%0t: sorted_value expected %0d got %0d", $time, e.value, v);
            end
            if (eol !== e.eol) begin
                errors++;
                $display("%0t: end_of_list expected %0b got %0b", $time, e.eol, eol);
            end
            if (ovf !== e.ovf) begin
                errors++;
                $display("%0t: overflowed expected %0b got %0b", $time, e.ovf, ovf);
            end
        endfunction

        function int unsigned outstanding();
            return due.size();
        endfunction

        function void flag_leftover();
            if (due.size() != 0) begin
                errors += due.size();
                $display("%0t: %0d results never came, next expected %0d",
                         $time, due.size(), due[0].value);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    ssort_in_if  in_ch();
    ssort_out_if out_ch();

    selection_sort_engine #(.CAPACITY(DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    sorted_list_tracker tracker = new();

    bit          feed_calm;
    bit          drain_calm;
    t_value      list_buf[$];
    int unsigned items_sent;
    int unsigned lists_sent;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // both channels are sampled on the edge, before any update lands
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready)
            tracker.take_element(in_ch.value, in_ch.is_final);
        if (i_rst_n && $isunknown(out_ch.valid)) begin
            tracker.errors++;
            $display("%0t: output valid unknown", $time);
        end
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready)
            tracker.check_output(out_ch.sorted_value, out_ch.end_of_list,
                                 out_ch.overflowed);
    end

    // result side: random hold-off before each item, none while drain_calm
    initial begin
        int unsigned gap;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            gap = drain_calm ? 0 : $urandom_range(0, 17);
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
        end
    end

    task automatic send_item(t_value v, logic fin);
        int unsigned gap;
        gap = feed_calm ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.value    <= v;
        in_ch.is_final <= fin;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        items_sent++;
    endtask

    task automatic send_list();
        for (int i = 0; i < list_buf.size(); i++)
            send_item(list_buf[i], i == list_buf.size() - 1);
        list_buf.delete();
        lists_sent++;
    endtask

    // hold the sender until every owed result is out
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.outstanding() != 0)
            @(posedge i_clk);
    endtask

    function automatic t_value draw_value(t_value_mix mix);
        if (mix == MIX_ANY)
            mix = t_value_mix'($urandom_range(0, 2));
        case (mix)
            MIX_NARROW:  return t_value'(int'($urandom_range(0, 8)) - 4);
            MIX_EXTREME: begin
                case ($urandom_range(0, 4))
                    0:       return VAL_MIN;
                    1:       return VAL_MAX;
                    2:       return -1;
                    3:       return 0;
                    default: return 1;
                endcase
            end
            default:     return t_value'($urandom);
        endcase
    endfunction

    initial begin
        int unsigned target;
        int unsigned len;
        t_value_mix  mix;

        in_ch.valid    <= 1'b0;
        in_ch.value    <= '0;
        in_ch.is_final <= 1'b0;
        i_rst_n        <= 1'b0;
        feed_calm      = 1'b0;
        drain_calm     = 1'b0;
        items_sent     = 0;
        lists_sent     = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // one-element list
        list_buf.push_back(0);
        send_list();
        // signed extremes
        list_buf.push_back(VAL_MIN);
        list_buf.push_back(VAL_MAX);
        list_buf.push_back(-1);
        list_buf.push_back(0);
        list_buf.push_back(1);
        send_list();
        // ties
        list_buf.push_back(5);
        list_buf.push_back(-5);
        list_buf.push_back(5);
        send_list();
        wait_drained();
        // full buffer, then a non-final and the final item both dropped
        for (int i = 0; i < DEPTH; i++)
            list_buf.push_back(t_value'(1000 - 137 * i));
        list_buf.push_back(VAL_MIN);
        list_buf.push_back(VAL_MIN);
        send_list();

        target = 230;
        while (items_sent < target) begin
            case ($urandom_range(0, 9))
                0, 1:    len = $urandom_range(1, 3);
                7:       len = DEPTH;
                8, 9:    len = $urandom_range(DEPTH + 1, DEPTH + 6);
                default: len = $urandom_range(4, DEPTH);
            endcase
            mix        = t_value_mix'($urandom_range(0, 3));
            feed_calm  = ($urandom_range(0, 3) == 0);
            drain_calm = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < int'(len); k++)
                list_buf.push_back(draw_value(mix));
            send_list();
            if ($urandom_range(0, 4) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (200) @(posedge i_clk);
        tracker.flag_leftover();

        $display("Sent %0d items in %0d lists, %0d of them overflowing the buffer;",
                 items_sent, lists_sent, tracker.overflow_lists);
        $display("checked %0d sorted results under random stalls on both sides.",
                 tracker.results_checked);
        if (tracker.errors == 0)
            $display("selection_sort_engine test passed");
        else
            $display("selection_sort_engine test failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("selection_sort_engine test failed");
        $finish;
    end

endmodule

// ===== selection_sort_engine.f =====
rtl/ssort_pkg.sv
rtl/ssort_if.sv
rtl/ssort_dp.sv
rtl/ssort_ctrl.sv
rtl/selection_sort_engine.sv
rtl/ssort_checker.sv
sim/tb_top.sv
